// ===== design/heartbeat_epoch_liveness_monitor_assert.svh =====
// Assertion macros shared by the liveness monitor checker.
// Depends on nothing; the including module provides clk and rst.
`ifndef HEARTBEAT_EPOCH_LIVENESS_MONITOR_ASSERT_SVH
`define HEARTBEAT_EPOCH_LIVENESS_MONITOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HBM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define HBM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/hbm_pkg.sv =====
// Package of the heartbeat liveness monitor: widths, codes and sequencer states.
// Used by the top level, the checker; depends on nothing.
package hbm_pkg;

  localparam int NODES_DEF  = 16;
  localparam int WINDOW_DEF = 4;
  localparam int MAX_OUT    = 16;
  localparam int OUT_CNT_W  = 5;

  localparam int TIME_W    = 48;
  localparam int IP_W      = 32;
  localparam int IV_W      = 16;
  localparam int CFG_W     = 48;
  localparam int CFG_IDX_W = 2;
  localparam int ALU_W     = 64;
  localparam int STEP_W    = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_EPOCH_ORIGIN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EPOCH_INTERVAL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SELF_ADDRESS   = 2'd2;

  localparam logic ACT_HEARTBEAT = 1'b0;
  localparam logic ACT_TICK      = 1'b1;

  localparam logic [IV_W-1:0] INTERVAL_RST = 16'd1000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HB_SUB,
    ST_HB_DIV,
    ST_HB_NCALC,
    ST_HB_CHECK,
    ST_HB_SCAN,
    ST_HB_APPLY,
    ST_TK_MUL,
    ST_TK_CMP,
    ST_EM_SEL,
    ST_EM_LOAD,
    ST_TK_DONE
  } state_t;

endpackage

// ===== design/hbm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module hbm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/heartbeat_epoch_liveness_monitor.sv =====
// Top level of the heartbeat liveness monitor: sequencer, shared 64-bit adder,
// epoch window and node table. Depends on hbm_pkg and hbm_ram.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+----------------------------------------
//   in      | request   | in_valid/in_stall  | action, source_ip, beat_time, tick_time
//   out     | result    | out_valid/out_stall| expired_ip, expired_epoch, last
//   cfg     | write     | cfg_write          | cfg_index, cfg_data
//
// A heartbeat runs the bit-serial division by the epoch interval, then searches the
// node table slot by slot for the source address.
// A tick forms the deadline product by shift-add and compares it; if the deadline
// is reached, it loads each expired source, up to MAX_OUT of them, into the output
// register in turn and retires the epoch. A stalled result holds the emission.
// Reset is synchronous; no clearing pass is needed. in_stall is high while one
// request is being worked on; a finished result may wait in the output register.
module heartbeat_epoch_liveness_monitor
  import hbm_pkg::*;
#(
  parameter int NODES        = NODES_DEF,
  parameter int EPOCH_WINDOW = WINDOW_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 action,
  input  logic [IP_W-1:0]      source_ip,
  input  logic [TIME_W-1:0]    beat_time,
  input  logic [TIME_W-1:0]    tick_time,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [IP_W-1:0]      expired_ip,
  output logic [TIME_W-1:0]    expired_epoch,
  output logic                 last,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int NODE_W = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int WIN_W  = $clog2(EPOCH_WINDOW);
  localparam logic [NODE_W:0] NODE_CNT = NODE_W'(NODES) == 0 && NODES > 0 ?
                                         (NODE_W+1)'(NODES) : (NODE_W+1)'(NODES);
  localparam logic [WIN_W:0]  WIN_CNT  = (WIN_W+1)'(EPOCH_WINDOW);
  localparam logic [WIN_W-1:0] WIN_LAST = WIN_W'(EPOCH_WINDOW - 1);

  // Sequencer and configuration.
  state_t state, state_next;
  logic [TIME_W-1:0] epoch_origin;
  logic [IV_W-1:0]   epoch_interval;
  logic [IP_W-1:0]   self_address;

  // Operands of the request in flight.
  logic [IP_W-1:0]   op_ip;
  logic [TIME_W-1:0] op_time;

  // Working registers of the shared adder.
  logic [ALU_W-1:0]  acc;
  logic [ALU_W-1:0]  msh;
  logic [IV_W-1:0]   iv_sh;
  logic [TIME_W-1:0] dq;
  logic [IV_W-1:0]   rem;
  logic [STEP_W-1:0] step;
  logic [TIME_W+1:0] n_val;

  // Epoch window.
  logic [NODES-1:0]  members   [EPOCH_WINDOW];
  logic [TIME_W-1:0] tag       [EPOCH_WINDOW];
  logic              tag_valid [EPOCH_WINDOW];
  logic [TIME_W-1:0] next_epoch;
  logic [WIN_W-1:0]  next_slot;

  // Heartbeat insert bookkeeping.
  logic [WIN_W-1:0]  slot_n;
  logic [WIN_W-1:0]  slot_e;
  logic              clear_e;
  logic [NODE_W-1:0] node_idx;
  logic [NODE_W:0]   scan_cnt;
  logic              chk_valid;
  logic [NODE_W-1:0] chk_idx;

  // Expiry emission.
  logic [NODES-1:0]     rem_mask;
  logic [NODE_W-1:0]    emit_idx;
  logic                 emit_last;
  logic [OUT_CNT_W-1:0] out_cnt;

  // Shared adder. For a subtraction the carry out means a >= b.
  logic [ALU_W-1:0] alu_a, alu_b;
  logic             alu_sub;
  logic [ALU_W:0]   alu_sum;
  logic             alu_ge;

  logic [IV_W-1:0] iv_hb;
  logic in_accept, out_free, out_load;

  // Node table port.
  logic              ram_we;
  logic [NODE_W-1:0] ram_raddr;
  logic [IP_W-1:0]   ram_rdata;

  // Derived combinational terms.
  logic [NODES-1:0]  used;
  logic [NODE_W-1:0] first_free;
  logic              any_free;
  logic              match;
  logic              scan_done;
  logic [NODE_W-1:0] low_idx;
  logic [NODES-1:0]  low_onehot;
  logic [NODES-1:0]  rem_clr;
  logic [NODES-1:0]  node_onehot;

  logic [TIME_W+1:0] ne_ext, ne_lim;
  logic              hb_late, hb_full, hb_conflict, hb_go, e_ok;
  logic [WIN_W-1:0]  off;
  logic [WIN_W:0]    slot_sum;
  logic [WIN_W-1:0]  slot_n_c, slot_e_c;
  logic              tick_hit;

  assign in_accept = in_valid && !in_stall;
  assign in_stall  = (state != ST_IDLE);
  assign out_free  = !out_valid || !out_stall;
  assign out_load  = (state == ST_EM_LOAD) && out_free;

  // A zero interval divides as one; the deadline product uses the raw value.
  assign iv_hb = (epoch_interval == '0) ? IV_W'(1) : epoch_interval;

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state)
      ST_HB_SUB: begin
        alu_a   = ALU_W'(op_time);
        alu_b   = ALU_W'(epoch_origin);
        alu_sub = 1'b1;
      end
      ST_HB_DIV: begin
        alu_a   = ALU_W'({rem, dq[TIME_W-1]});
        alu_b   = ALU_W'(iv_hb);
        alu_sub = 1'b1;
      end
      ST_HB_NCALC: begin
        alu_a = ALU_W'(dq);
        alu_b = ALU_W'(2);
      end
      ST_TK_MUL: begin
        alu_a = acc;
        alu_b = iv_sh[0] ? msh : '0;
      end
      ST_TK_CMP: begin
        alu_a   = ALU_W'(op_time);
        alu_b   = acc;
        alu_sub = 1'b1;
      end
      default: begin
        alu_a = '0;
      end
    endcase
  end

  assign alu_sum = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
                 + (ALU_W+1)'(alu_sub);
  assign alu_ge  = alu_sum[ALU_W];

  // A slot is in use while some live epoch still lists it.
  always_comb begin
    for (int i = 0; i < NODES; i++) begin
      used[i] = 1'b0;
      for (int w = 0; w < EPOCH_WINDOW; w++) begin
        used[i] = used[i] | (tag_valid[w] & members[w][i]);
      end
    end
  end

  always_comb begin
    first_free = '0;
    low_idx    = '0;
    for (int i = NODES - 1; i >= 0; i--) begin
      if (!used[i]) begin
        first_free = NODE_W'(i);
      end
      if (rem_mask[i]) begin
        low_idx = NODE_W'(i);
      end
    end
    for (int i = 0; i < NODES; i++) begin
      low_onehot[i]  = (low_idx == NODE_W'(i));
      node_onehot[i] = (node_idx == NODE_W'(i));
    end
  end

  assign any_free  = ~used != '0;
  assign rem_clr   = rem_mask & ~low_onehot;
  assign scan_done = (scan_cnt == NODE_CNT);
  assign match     = chk_valid && used[chk_idx] && (ram_rdata == op_ip);

  // Window checks for the epoch after the heartbeat's epoch. Live tags always lie
  // in the window starting at next_epoch, so their slots follow next_slot in order.
  assign ne_ext      = (TIME_W+2)'(next_epoch);
  assign ne_lim      = ne_ext + (TIME_W+2)'(EPOCH_WINDOW);
  assign hb_late     = n_val < ne_ext;
  assign hb_full     = (n_val[TIME_W+1:TIME_W] != 2'b00) || (n_val >= ne_lim);
  assign off         = n_val[WIN_W-1:0] - next_epoch[WIN_W-1:0];
  assign slot_sum    = {1'b0, next_slot} + {1'b0, off};
  assign slot_n_c    = (slot_sum >= WIN_CNT) ? WIN_W'(slot_sum - WIN_CNT)
                                             : slot_sum[WIN_W-1:0];
  assign slot_e_c    = (slot_n_c == '0) ? WIN_LAST : slot_n_c - WIN_W'(1);
  assign hb_conflict = tag_valid[slot_n_c] && (tag[slot_n_c] != n_val[TIME_W-1:0]);
  assign hb_go       = !hb_late && !hb_full && !hb_conflict;
  assign e_ok        = n_val > ne_ext;
  assign tick_hit    = tag_valid[next_slot] && (tag[next_slot] == next_epoch);

  // Node table: written when a new source takes the first free slot.
  assign ram_we = (state == ST_HB_SCAN) && !match && scan_done && !chk_valid && any_free;

  always_comb begin
    case (state)
      ST_HB_SCAN: ram_raddr = scan_cnt[NODE_W-1:0];
      ST_EM_SEL:  ram_raddr = low_idx;
      default:    ram_raddr = emit_idx;
    endcase
  end

  hbm_ram #(
    .WIDTH(IP_W),
    .DEPTH(NODES)
  ) u_node_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(first_free),
    .wdata(op_ip),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_accept) begin
          state_next = (action == ACT_TICK) ? ST_TK_MUL : ST_HB_SUB;
        end
      end
      ST_HB_SUB: begin
        state_next = (op_ip == self_address || !alu_ge) ? ST_IDLE : ST_HB_DIV;
      end
      ST_HB_DIV: begin
        if (step == STEP_W'(TIME_W - 1)) begin
          state_next = ST_HB_NCALC;
        end
      end
      ST_HB_NCALC: state_next = ST_HB_CHECK;
      ST_HB_CHECK: state_next = hb_go ? ST_HB_SCAN : ST_IDLE;
      ST_HB_SCAN: begin
        if (match) begin
          state_next = ST_HB_APPLY;
        end else if (scan_done && !chk_valid) begin
          state_next = any_free ? ST_HB_APPLY : ST_IDLE;
        end
      end
      ST_HB_APPLY: state_next = ST_IDLE;
      ST_TK_MUL: begin
        if (step == STEP_W'(IV_W - 1)) begin
          state_next = ST_TK_CMP;
        end
      end
      ST_TK_CMP: state_next = alu_ge ? ST_EM_SEL : ST_IDLE;
      ST_EM_SEL: begin
        if (rem_mask == '0 || out_cnt == OUT_CNT_W'(MAX_OUT)) begin
          state_next = ST_TK_DONE;
        end else begin
          state_next = ST_EM_LOAD;
        end
      end
      ST_EM_LOAD: begin
        if (out_free) begin
          state_next = emit_last ? ST_TK_DONE : ST_EM_SEL;
        end
      end
      ST_TK_DONE: state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // Configuration and window state.
  always_ff @(posedge clk) begin
    if (rst) begin
      epoch_origin   <= '0;
      epoch_interval <= INTERVAL_RST;
      self_address   <= '0;
      next_epoch     <= TIME_W'(1);
      next_slot      <= WIN_W'(1);
      out_valid      <= 1'b0;
      for (int w = 0; w < EPOCH_WINDOW; w++) begin
        members[w]   <= '0;
        tag[w]       <= '0;
        tag_valid[w] <= 1'b0;
      end
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_EPOCH_ORIGIN:   epoch_origin   <= cfg_data[TIME_W-1:0];
          CFG_EPOCH_INTERVAL: epoch_interval <= cfg_data[IV_W-1:0];
          CFG_SELF_ADDRESS:   self_address   <= cfg_data[IP_W-1:0];
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (state == ST_HB_APPLY) begin
        if (clear_e) begin
          members[slot_e][node_idx] <= 1'b0;
        end
        if (!tag_valid[slot_n]) begin
          tag_valid[slot_n] <= 1'b1;
          tag[slot_n]       <= n_val[TIME_W-1:0];
          members[slot_n]   <= node_onehot;
        end else begin
          members[slot_n][node_idx] <= 1'b1;
        end
      end
      if (state == ST_TK_DONE) begin
        tag_valid[next_slot] <= 1'b0;
        members[next_slot]   <= '0;
        tag[next_slot]       <= '0;
        next_epoch           <= next_epoch + TIME_W'(1);
        // The epoch counter wraps to zero, whose slot is zero.
        if (next_epoch == '1 || next_slot == WIN_LAST) begin
          next_slot <= '0;
        end else begin
          next_slot <= next_slot + WIN_W'(1);
        end
      end
    end
  end

  // Datapath registers of the request in flight.
  always_ff @(posedge clk) begin
    if (rst) begin
      chk_valid <= 1'b0;
    end else begin
      chk_valid <= (state == ST_HB_SCAN) && !scan_done && !match;
    end
    chk_idx <= scan_cnt[NODE_W-1:0];
    case (state)
      ST_IDLE: begin
        op_ip   <= source_ip;
        op_time <= (action == ACT_TICK) ? tick_time : beat_time;
        acc     <= ALU_W'(epoch_origin);
        msh     <= ALU_W'(next_epoch);
        iv_sh   <= epoch_interval;
        step    <= '0;
      end
      ST_HB_SUB: begin
        dq   <= alu_sum[TIME_W-1:0];
        rem  <= '0;
        step <= '0;
      end
      ST_HB_DIV: begin
        rem  <= alu_ge ? alu_sum[IV_W-1:0] : {rem[IV_W-2:0], dq[TIME_W-1]};
        dq   <= {dq[TIME_W-2:0], alu_ge};
        step <= step + STEP_W'(1);
      end
      ST_HB_NCALC: begin
        n_val <= alu_sum[TIME_W+1:0];
      end
      ST_HB_CHECK: begin
        slot_n   <= slot_n_c;
        slot_e   <= slot_e_c;
        clear_e  <= e_ok && tag_valid[slot_e_c];
        scan_cnt <= '0;
      end
      ST_HB_SCAN: begin
        if (match) begin
          node_idx <= chk_idx;
        end else if (scan_done) begin
          node_idx <= first_free;
        end else begin
          scan_cnt <= scan_cnt + (NODE_W+1)'(1);
        end
      end
      ST_TK_MUL: begin
        acc   <= alu_sum[ALU_W-1:0];
        msh   <= {msh[ALU_W-2:0], 1'b0};
        iv_sh <= {1'b0, iv_sh[IV_W-1:1]};
        step  <= step + STEP_W'(1);
      end
      ST_TK_CMP: begin
        rem_mask <= tick_hit ? members[next_slot] : '0;
        out_cnt  <= '0;
      end
      ST_EM_SEL: begin
        emit_idx  <= low_idx;
        rem_mask  <= rem_clr;
        emit_last <= (rem_clr == '0) || (out_cnt == OUT_CNT_W'(MAX_OUT - 1));
      end
      ST_EM_LOAD: begin
        if (out_free) begin
          expired_ip    <= ram_rdata;
          expired_epoch <= next_epoch;
          last          <= emit_last;
          out_cnt       <= out_cnt + OUT_CNT_W'(1);
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== design/hbm_checker.sv =====
// Port-level checker of the heartbeat liveness monitor, bound to the top level.
// Depends on hbm_pkg and heartbeat_epoch_liveness_monitor_assert.svh.
`include "heartbeat_epoch_liveness_monitor_assert.svh"

module hbm_checker
  import hbm_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic [IP_W-1:0]      expired_ip,
  input logic [TIME_W-1:0]    expired_epoch,
  input logic                 last
);

  // Every accepted request leaves the block busy once it has been taken.
  `HBM_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "idle after accept")

  // A new result only appears while a tick is being worked on.
  `HBM_ASSERT_NOW(a_result_while_busy, $rose(out_valid), in_stall, "result while idle")

  // A non-final result leaves the tick unfinished.
  `HBM_ASSERT_NEXT(a_more_to_come, out_valid && !out_stall && !last, in_stall,
                   "tick ended before its final result")

  // A stalled result keeps its payload.
  `HBM_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
                   out_valid && $stable(expired_ip) && $stable(expired_epoch) && $stable(last),
                   "stalled result changed")

endmodule

bind heartbeat_epoch_liveness_monitor hbm_checker u_hbm_checker (.*);
